[hdl/csso_pkg.sv]
// Shared types, constants and the segment font for the clock seven-segment
// shift-out unit. No dependencies.
package csso_pkg;

	// Display modes
	localparam logic [2:0] MODE_NORMAL     = 3'd0;
	localparam logic [2:0] MODE_TIME_HOURS = 3'd1;
	localparam logic [2:0] MODE_TIME_MINS  = 3'd2;
	localparam logic [2:0] MODE_ALARM_SET  = 3'd3;
	localparam logic [2:0] MODE_ALARM_HRS  = 3'd4;
	localparam logic [2:0] MODE_ALARM_MINS = 3'd5;
	localparam logic [2:0] MODE_SLEEP_MINS = 3'd6;

	localparam logic [7:0] SEG_COLON = 8'h80;
	localparam logic [7:0] SEG_BLANK = 8'h00;

	localparam int BITS_PER_FRAME = 32;
	localparam int CNT_W          = $clog2(BITS_PER_FRAME);
	localparam int QUEUE_DEPTH    = 2;

	// Reciprocal for divide by 10 on 7-bit values: (v * 205) >> 11
	localparam logic [7:0] RECIP_10   = 8'd205;
	localparam int         RECIP_SHIFT = 11;

	typedef logic [BITS_PER_FRAME-1:0] frame_t;

	// Map one decimal digit to its segment pattern; no glyph shows blank
	function automatic logic [7:0] seg_font(input logic [3:0] digit);
		logic [7:0] seg;
		case (digit)
			4'd0: seg = 8'h3f;
			4'd1: seg = 8'h06;
			4'd2: seg = 8'h5b;
			4'd3: seg = 8'h4f;
			4'd4: seg = 8'h66;
			4'd5: seg = 8'h6d;
			4'd6: seg = 8'h7d;
			4'd7: seg = 8'h07;
			4'd8: seg = 8'h7f;
			4'd9: seg = 8'h6f;
			default: seg = SEG_BLANK;
		endcase
		return seg;
	endfunction

endpackage

[hdl/csso_front.sv]
// Front end: turns one refresh request into the four segment bytes.
// Depends on csso_pkg.
module csso_front import csso_pkg::*; (
	input  logic [2:0] display_mode,
	input  logic [6:0] clock_hours,
	input  logic [6:0] clock_minutes,
	input  logic       clock_colon,
	input  logic [6:0] wake_hours,
	input  logic [6:0] alarm_minutes,
	input  logic       alarm_enabled,
	input  logic [6:0] sleep_count,
	output frame_t     frame
);

	logic [6:0]  left_val;
	logic [6:0]  right_val;
	logic        show_left;
	logic        show_right;
	logic        colon1;
	logic        colon2;
	logic [14:0] left_prod;
	logic [14:0] right_prod;
	logic [3:0]  left_tens;
	logic [3:0]  right_tens;
	logic [3:0]  left_units;
	logic [3:0]  right_units;
	logic [7:0]  dig0;
	logic [7:0]  dig1;
	logic [7:0]  dig2;
	logic [7:0]  dig3;

	// Select the shown values and colon flags for the mode
	always_comb begin
		left_val   = clock_hours;
		right_val  = clock_minutes;
		show_left  = 1'b0;
		show_right = 1'b0;
		colon1     = 1'b0;
		colon2     = 1'b0;
		case (display_mode)
			MODE_NORMAL: begin
				show_left  = 1'b1;
				show_right = 1'b1;
				colon2     = clock_colon;
			end
			MODE_TIME_HOURS: begin
				show_left = 1'b1;
				colon2    = clock_colon;
			end
			MODE_TIME_MINS: begin
				show_right = 1'b1;
				colon2     = clock_colon;
			end
			MODE_ALARM_SET: begin
				left_val   = wake_hours;
				right_val  = alarm_minutes;
				show_left  = 1'b1;
				show_right = 1'b1;
				colon2     = alarm_enabled;
			end
			MODE_ALARM_HRS: begin
				left_val  = wake_hours;
				show_left = 1'b1;
				colon2    = 1'b1;
			end
			MODE_ALARM_MINS: begin
				right_val  = alarm_minutes;
				show_right = 1'b1;
				colon2     = 1'b1;
			end
			MODE_SLEEP_MINS: begin
				right_val  = sleep_count;
				show_right = 1'b1;
				colon1     = 1'b1;
				colon2     = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Split each value by 10 through the reciprocal
	assign left_prod   = 15'(left_val) * 15'(RECIP_10);
	assign right_prod  = 15'(right_val) * 15'(RECIP_10);
	assign left_tens   = 4'(left_prod >> RECIP_SHIFT);
	assign right_tens  = 4'(right_prod >> RECIP_SHIFT);
	assign left_units  = 4'(left_val - 7'(left_tens * 7'd10));
	assign right_units = 4'(right_val - 7'(right_tens * 7'd10));

	// Map digits through the font, blank the hidden fields, add colons
	assign dig0 = show_left ? seg_font(left_tens) : SEG_BLANK;
	assign dig1 = (show_left ? seg_font(left_units) : SEG_BLANK)
		| (colon1 ? SEG_COLON : SEG_BLANK);
	assign dig2 = (show_right ? seg_font(right_tens) : SEG_BLANK)
		| (colon2 ? SEG_COLON : SEG_BLANK);
	assign dig3 = show_right ? seg_font(right_units) : SEG_BLANK;

	assign frame = {dig0, dig1, dig2, dig3};

endmodule

[hdl/csso_queue.sv]
// Short frame queue between the front end and the shifter.
// Depends on csso_pkg.
module csso_queue import csso_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  frame_t wr_data,
	input  logic   rd_en,
	output frame_t rd_data,
	output logic   full,
	output logic   empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W_Q = $clog2(DEPTH + 1);

	frame_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (count_q == CNT_W_Q'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Store incoming frames
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/csso_back.sv]
// Back end: shifts each frame out one bit per transaction, MSB first,
// and marks the last bit. Depends on csso_pkg.
module csso_back import csso_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_empty,
	input  frame_t q_data,
	output logic   q_pop,
	output logic   serial_data,
	output logic   latch_after,
	output logic   empty,
	input  logic   pop
);

	frame_t           shift_q;
	logic [CNT_W-1:0] cnt_q;
	logic             valid_q;
	logic             last_bit;
	logic             taken;
	logic             load;

	assign last_bit    = (cnt_q == CNT_W'(BITS_PER_FRAME - 1));
	assign taken       = valid_q && pop;
	// Load a new frame when idle or when the last bit leaves
	assign load        = !q_empty && (!valid_q || (taken && last_bit));
	assign q_pop       = load;
	assign serial_data = shift_q[BITS_PER_FRAME-1];
	assign latch_after = last_bit;
	assign empty       = !valid_q;

	// Hold, shift or reload the output frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				cnt_q   <= '0;
			end else if (taken) begin
				if (last_bit) begin
					valid_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= q_data;
		end else if (taken) begin
			shift_q <= {shift_q[BITS_PER_FRAME-2:0], 1'b0};
		end
	end

endmodule

[hdl/clock_seven_segment_shift_out_unit.sv]
// Top level of the clock seven-segment shift-out unit.
// Depends on csso_pkg, csso_front, csso_queue and csso_back.
//
// Usage:
//   Input side is a queue: drive the request fields with push high; the
//   request is taken on a rising edge with push high and full low. Each
//   request carries mode, clock, alarm and sleep values.
//   Result side is a queue: while empty is low, serial_data holds the
//   next segment bit (digit 0 first, MSB first) and latch_after marks the
//   32nd bit of a frame; pop high with empty low takes it.
// Path: a request taken into an idle unit is first written into the queue,
//   then loaded into the shifter, which shows its first bit.
// Throughput: 32 result transactions per request, one per cycle while pop
//   is high; the 32-bit shifter sets the pace at which requests are taken.
//   A new frame loads in the cycle its predecessor's last bit is taken,
//   so the bit stream has no gaps while frames wait in the queue.
// Stall: with pop low the current bit holds; up to DEPTH formatted frames
//   wait in the queue, after which full rises.
// Reset: arst_n clears the queue and the shifter; empty goes high.
module clock_seven_segment_shift_out_unit import csso_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] display_mode,
	input  logic [6:0] clock_hours,
	input  logic [6:0] clock_minutes,
	input  logic       clock_colon,
	input  logic [6:0] wake_hours,
	input  logic [6:0] alarm_minutes,
	input  logic       alarm_enabled,
	input  logic [6:0] sleep_count,
	output logic       empty,
	input  logic       pop,
	output logic       serial_data,
	output logic       latch_after
);

	frame_t frame;
	frame_t q_data;
	logic   q_empty;
	logic   q_pop;

	// Format the request into segment bytes
	csso_front u_front (
		.display_mode  (display_mode),
		.clock_hours   (clock_hours),
		.clock_minutes (clock_minutes),
		.clock_colon   (clock_colon),
		.wake_hours    (wake_hours),
		.alarm_minutes (alarm_minutes),
		.alarm_enabled (alarm_enabled),
		.sleep_count   (sleep_count),
		.frame         (frame)
	);

	// Buffer formatted frames
	csso_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (frame),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.full    (full),
		.empty   (q_empty)
	);

	// Shift frames out
	csso_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.serial_data (serial_data),
		.latch_after (latch_after),
		.empty       (empty),
		.pop         (pop)
	);

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for clock_seven_segment_shift_out_unit: predicts each
// 32-bit serial frame from the refresh request and checks every bit.
// Depends on csso_pkg and the unit's RTL.
module tb import csso_pkg::*; ;

	localparam logic [2:0] MODE_BLANK = 3'd7;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_PER_PHASE = 28;

	// segment patterns for the decimal digits
	localparam logic [7:0] GLYPH [0:9] = '{
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
	};

	typedef struct packed {
		logic [2:0] mode;
		logic [6:0] clk_hours;
		logic [6:0] clk_minutes;
		logic       colon;
		logic [6:0] alm_hours;
		logic [6:0] alm_minutes;
		logic       alm_on;
		logic [6:0] sleep_min;
	} refresh_t;

	typedef struct packed {
		logic data;
		logic latch;
	} shift_bit_t;

	typedef enum {PH_STEADY, PH_SEND_SPARSE, PH_RECV_STALL, PH_BOTH_IDLE} phase_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     push = 1'b0;
	logic     pop = 1'b0;
	logic     full;
	logic     empty;
	logic     serial_data;
	logic     latch_after;
	refresh_t req = '0;

	refresh_t   pending_q[$];
	shift_bit_t expected_bits_q[$];
	phase_t     phase = PH_STEADY;
	int         errors = 0;
	int         idle_cycles = 0;

	clock_seven_segment_shift_out_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.display_mode (req.mode),
		.clock_hours  (req.clk_hours),
		.clock_minutes(req.clk_minutes),
		.clock_colon  (req.colon),
		.wake_hours   (req.alm_hours),
		.alarm_minutes(req.alm_minutes),
		.alarm_enabled(req.alm_on),
		.sleep_count  (req.sleep_min),
		.empty        (empty),
		.pop          (pop),
		.serial_data  (serial_data),
		.latch_after  (latch_after)
	);

	always #2 clk = ~clk;

	// Map one digit to segments; tens digits past nine have no glyph
	function automatic logic [7:0] glyph_of(input int d);
		if (d > 9)
			return SEG_BLANK;
		return GLYPH[d];
	endfunction

	function automatic logic [15:0] digit_pair(input logic [6:0] v);
		return {glyph_of(int'(v) / 10), glyph_of(int'(v) % 10)};
	endfunction

	// Build the four display bytes, digit 0 in the top byte
	function automatic logic [31:0] segment_frame(input refresh_t r);
		logic [7:0] d0, d1, d2, d3;
		d0 = SEG_BLANK;
		d1 = SEG_BLANK;
		d2 = SEG_BLANK;
		d3 = SEG_BLANK;
		case (r.mode)
			MODE_NORMAL: begin
				{d0, d1} = digit_pair(r.clk_hours);
				{d2, d3} = digit_pair(r.clk_minutes);
				if (r.colon) d2 |= SEG_COLON;
			end
			MODE_TIME_HOURS: begin
				{d0, d1} = digit_pair(r.clk_hours);
				if (r.colon) d2 |= SEG_COLON;
			end
			MODE_TIME_MINS: begin
				{d2, d3} = digit_pair(r.clk_minutes);
				if (r.colon) d2 |= SEG_COLON;
			end
			MODE_ALARM_SET: begin
				{d0, d1} = digit_pair(r.alm_hours);
				{d2, d3} = digit_pair(r.alm_minutes);
				if (r.alm_on) d2 |= SEG_COLON;
			end
			MODE_ALARM_HRS: begin
				{d0, d1} = digit_pair(r.alm_hours);
				d2 |= SEG_COLON;
			end
			MODE_ALARM_MINS: begin
				{d2, d3} = digit_pair(r.alm_minutes);
				d2 |= SEG_COLON;
			end
			MODE_SLEEP_MINS: begin
				{d2, d3} = digit_pair(r.sleep_min);
				d1 |= SEG_COLON;
				d2 |= SEG_COLON;
			end
			default: ;
		endcase
		return {d0, d1, d2, d3};
	endfunction

	function automatic bit send_idle();
		case (phase)
			PH_SEND_SPARSE: return $urandom_range(99) < 88;
			PH_BOTH_IDLE:   return $urandom_range(99) < 19;
			default:        return 1'b0;
		endcase
	endfunction

	function automatic bit recv_stall();
		case (phase)
			PH_RECV_STALL: return $urandom_range(99) < 88;
			PH_BOTH_IDLE:  return $urandom_range(99) < 19;
			default:       return 1'b0;
		endcase
	endfunction

	// Mostly in-range values, some past 99 to hit the blank tens digit
	function automatic logic [6:0] rand_value();
		if ($urandom_range(99) < 80)
			return 7'($urandom_range(99));
		return 7'($urandom_range(127));
	endfunction

	function automatic refresh_t rand_req();
		refresh_t r;
		r.mode        = 3'($urandom_range(7));
		r.clk_hours   = rand_value();
		r.clk_minutes = rand_value();
		r.colon       = 1'($urandom_range(1));
		r.alm_hours   = rand_value();
		r.alm_minutes = rand_value();
		r.alm_on      = 1'($urandom_range(1));
		r.sleep_min   = rand_value();
		return r;
	endfunction

	task automatic add_req(input logic [2:0] mode, input logic [6:0] ch, input logic [6:0] cm,
			input logic cc, input logic [6:0] ah, input logic [6:0] am, input logic ae,
			input logic [6:0] sc);
		pending_q.push_back('{mode, ch, cm, cc, ah, am, ae, sc});
	endtask

	// Drain: hold off new requests until every expected bit has been taken
	task automatic wait_drained();
		while (pending_q.size() != 0 || push)
			@(negedge clk);
		while (expected_bits_q.size() != 0)
			@(negedge clk);
	endtask

	// Driver: present pending requests, predict the frame on each transaction
	always @(posedge clk) begin : drive
		logic [31:0] frame;
		if (arst_n) begin
			if (push && !full) begin
				frame = segment_frame(req);
				for (int k = 0; k < BITS_PER_FRAME; k++)
					expected_bits_q.push_back('{frame[31-k], k == BITS_PER_FRAME - 1});
				void'(pending_q.pop_front());
			end
			if (!(push && full)) begin
				if (pending_q.size() != 0 && !send_idle()) begin
					req  <= pending_q[0];
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each bit transaction with the oldest expectation
	always @(posedge clk) begin : watch
		shift_bit_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_bits_q.size() == 0) begin
					$error("unexpected transaction: serial_data=%0b latch_after=%0b",
						serial_data, latch_after);
					errors++;
				end else begin
					want = expected_bits_q.pop_front();
					if (serial_data !== want.data) begin
						$error("serial_data: expected %0b, actual %0b", want.data, serial_data);
						errors++;
					end
					if (latch_after !== want.latch) begin
						$error("latch_after: expected %0b, actual %0b", want.latch, latch_after);
						errors++;
					end
				end
			end
			pop <= !recv_stall();
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: every mode, field extremes, tens digits without a glyph
		add_req(MODE_NORMAL, 0, 0, 0, 0, 0, 0, 0);
		add_req(MODE_NORMAL, 127, 127, 1, 127, 127, 1, 127);
		add_req(MODE_NORMAL, 12, 34, 1, 56, 78, 1, 90);
		add_req(MODE_NORMAL, 99, 59, 0, 11, 22, 0, 33);
		add_req(MODE_NORMAL, 109, 110, 1, 5, 5, 0, 5);
		add_req(MODE_TIME_HOURS, 23, 45, 1, 55, 55, 1, 55);
		add_req(MODE_TIME_HOURS, 7, 45, 0, 55, 55, 1, 55);
		add_req(MODE_TIME_HOURS, 126, 3, 1, 0, 0, 0, 0);
		add_req(MODE_TIME_MINS, 23, 5, 1, 55, 55, 1, 55);
		add_req(MODE_TIME_MINS, 23, 88, 0, 55, 55, 0, 55);
		add_req(MODE_ALARM_SET, 12, 34, 0, 6, 30, 1, 77);
		add_req(MODE_ALARM_SET, 12, 34, 1, 100, 119, 0, 77);
		add_req(MODE_ALARM_HRS, 12, 34, 0, 120, 41, 0, 77);
		add_req(MODE_ALARM_MINS, 12, 34, 0, 41, 127, 1, 77);
		add_req(MODE_SLEEP_MINS, 12, 34, 1, 56, 78, 1, 0);
		add_req(MODE_SLEEP_MINS, 12, 34, 0, 56, 78, 0, 99);
		add_req(MODE_SLEEP_MINS, 12, 34, 0, 56, 78, 0, 105);
		add_req(MODE_BLANK, 127, 127, 1, 127, 127, 1, 127);
		wait_drained();

		// random requests, one batch per idling pattern
		for (int p = PH_STEADY; p <= PH_BOTH_IDLE; p++) begin
			phase = phase_t'(p);
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				pending_q.push_back(rand_req());
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

[clock_seven_segment_shift_out_unit.f]
hdl/csso_pkg.sv
hdl/csso_front.sv
hdl/csso_queue.sv
hdl/csso_back.sv
hdl/clock_seven_segment_shift_out_unit.sv
tb/tb.sv
